// ===== design/ring_fifo_with_checkpoint_top_defines.svh =====
// ----------------------------------------------------------------------------
// Ring FIFO with checkpoint - assertion macros
// Shared property forms for the checker; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef RING_FIFO_WITH_CHECKPOINT_TOP_DEFINES_SVH
`define RING_FIFO_WITH_CHECKPOINT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define RFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rfc_pkg.sv =====
// ----------------------------------------------------------------------------
// rfc_pkg
// Operation and status codes, field widths and the stage record of the
// ring FIFO with checkpoint.
// ----------------------------------------------------------------------------
`default_nettype none

package rfc_pkg;

  // Field widths of the transfers
  localparam int FUNC_W   = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 8;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_ENQ    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DEQ    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_FREEZE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_THAW   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Record of one operation waiting on the memory read
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                deq_ok;
    logic [FILL_W-1:0]   fill;
  } rfc_stage_t;

endpackage

`default_nettype wire

// ===== design/rfc_ifs.sv =====
// ----------------------------------------------------------------------------
// rfc_ifs
// Valid/ready channels of the ring FIFO: operation in, result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfc_in_if import rfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [DATA_W-1:0] item_data;

  modport source (output valid, output func, output item_data, input ready);
  modport sink   (input valid, input func, input item_data, output ready);
endinterface

interface rfc_out_if import rfc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   out_data;
  logic [FILL_W-1:0]   fill_level;

  modport source (output valid, output status, output out_data, output fill_level,
                  input ready);
  modport sink   (input valid, input status, input out_data, input fill_level,
                  output ready);
endinterface

`default_nettype wire

// ===== design/ring_fifo_with_checkpoint_top.sv =====
// ----------------------------------------------------------------------------
// Ring FIFO with checkpoint
// Each input transfer is one operation (enqueue, dequeue, freeze, thaw,
// clear) and yields exactly one result transfer with status, dequeued item
// and fill level. The block takes one operation per cycle while the result
// path is not stalled; a result passes through the synchronous read of the
// item memory and then through the output register. Pointers update at the
// transfer, so back-to-back operations see each other at once. The queue
// holds DEPTH-1 items; an enqueue into a full queue is rejected with status
// full. Freeze saves both pointers, thaw restores them, clear zeroes them.
// The item memory has no reset; slots never written must not be dequeued.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_fifo_with_checkpoint_top import rfc_pkg::*; #(
  parameter int DEPTH     = 256,
  parameter int ITEM_BITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rfc_in_if.sink     in_ch,
  rfc_out_if.source  out_ch
);

  localparam int             AW   = $clog2(DEPTH);
  localparam int             KEEP = (ITEM_BITS < DATA_W) ? ITEM_BITS : DATA_W;
  localparam logic [AW-1:0]  LAST = AW'(DEPTH - 1);
  localparam logic [AW:0]    SPAN = (AW + 1)'(DEPTH);

  // Pointers and checkpoint
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic [AW-1:0] wr_idx_r, wr_idx_nxt;
  logic [AW-1:0] sv_rd_r, sv_rd_nxt;
  logic [AW-1:0] sv_wr_r, sv_wr_nxt;

  // Memory and pipeline
  logic [ITEM_BITS-1:0] mem [DEPTH];
  logic [ITEM_BITS-1:0] rd_data_r;
  logic                 mem_we, mem_re;
  logic                 accept, out_load;
  logic                 s1_valid_r;
  rfc_stage_t           s1_r, s1_nxt;
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [DATA_W-1:0]    out_data_r;
  logic [FILL_W-1:0]    out_fill_r;

  logic [AW-1:0] rd_inc, wr_inc;
  logic [AW:0]   diff;

  assign accept       = in_ch.valid && in_ch.ready;
  assign out_load     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || out_load;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.out_data   = out_data_r;
  assign out_ch.fill_level = out_fill_r;

  // Decode the operation and compute the next pointers
  always_comb begin
    rd_inc        = (rd_idx_r == LAST) ? '0 : rd_idx_r + 1'b1;
    wr_inc        = (wr_idx_r == LAST) ? '0 : wr_idx_r + 1'b1;
    rd_idx_nxt    = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    sv_rd_nxt     = sv_rd_r;
    sv_wr_nxt     = sv_wr_r;
    s1_nxt.status = ST_OK;
    s1_nxt.deq_ok = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    case (in_ch.func)
      FN_ENQ: begin
        if (wr_inc == rd_idx_r) begin
          s1_nxt.status = ST_FULL;
        end else begin
          mem_we     = accept;
          wr_idx_nxt = wr_inc;
        end
      end
      FN_DEQ: begin
        if (rd_idx_r == wr_idx_r) begin
          s1_nxt.status = ST_EMPTY;
        end else begin
          mem_re        = accept;
          s1_nxt.deq_ok = 1'b1;
          rd_idx_nxt    = rd_inc;
        end
      end
      FN_FREEZE: begin
        sv_rd_nxt = rd_idx_r;
        sv_wr_nxt = wr_idx_r;
      end
      FN_THAW: begin
        rd_idx_nxt = sv_rd_r;
        wr_idx_nxt = sv_wr_r;
      end
      FN_CLEAR: begin
        rd_idx_nxt = '0;
        wr_idx_nxt = '0;
      end
      default: begin
      end
    endcase

    // Fill level after the operation, saturated to the field
    if (wr_idx_nxt >= rd_idx_nxt) begin
      diff = {1'b0, wr_idx_nxt} - {1'b0, rd_idx_nxt};
    end else begin
      diff = SPAN - {1'b0, rd_idx_nxt} + {1'b0, wr_idx_nxt};
    end
    s1_nxt.fill = (32'(diff) > 32'd255) ? 8'd255 : FILL_W'(diff);
  end

  // Item memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx_r] <= ITEM_BITS'(in_ch.item_data[KEEP-1:0]);
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  // Advance pointers and checkpoint on a transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
      wr_idx_r <= '0;
      sv_rd_r  <= '0;
      sv_wr_r  <= '0;
    end else if (accept) begin
      rd_idx_r <= rd_idx_nxt;
      wr_idx_r <= wr_idx_nxt;
      sv_rd_r  <= sv_rd_nxt;
      sv_wr_r  <= sv_wr_nxt;
    end
  end

  // Hold the operation record while its read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (out_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
  end

  // Output register: load the finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= s1_r.status;
      out_fill_r   <= s1_r.fill;
      out_data_r   <= s1_r.deq_ok ? DATA_W'(rd_data_r[KEEP-1:0]) : '0;
    end
  end

endmodule

`default_nettype wire

// ===== design/rfc_checker.sv =====
// ----------------------------------------------------------------------------
// rfc_checker
// Port-level checks of the ring FIFO result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ring_fifo_with_checkpoint_top_defines.svh"

module rfc_checker import rfc_pkg::*; #(
  parameter int DEPTH = 256
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [STATUS_W-1:0] status,
  input wire logic [DATA_W-1:0]   out_data,
  input wire logic [FILL_W-1:0]   fill_level
);

  localparam logic [FILL_W-1:0] FULL_FILL =
    (DEPTH - 1 > 255) ? 8'd255 : FILL_W'(DEPTH - 1);

  // A stalled result holds
  `RFC_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(out_data) && $stable(fill_level), "result changed while stalled")

  // Only a successful transfer carries data
  `RFC_ASSERT_NOW(a_err_no_data, out_valid && (status != ST_OK), out_data == '0, "data on a failed operation")

  // An empty dequeue reports an empty queue
  `RFC_ASSERT_NOW(a_empty_fill, out_valid && (status == ST_EMPTY), fill_level == '0, "empty status with items held")

  // A rejected enqueue reports a full queue
  `RFC_ASSERT_NOW(a_full_fill, out_valid && (status == ST_FULL), fill_level == FULL_FILL, "full status with room left")

endmodule

bind ring_fifo_with_checkpoint_top rfc_checker #(.DEPTH(DEPTH)) u_rfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .status     (out_ch.status),
  .out_data   (out_ch.out_data),
  .fill_level (out_ch.fill_level)
);

`default_nettype wire
